/* rtl/vmm_pkg.sv */
package vmm_pkg;

	// default matrix limits
	localparam int MAX_ROWS_DEF = 64;
	localparam int MAX_COLS_DEF = 64;

	// field widths
	localparam int IN_W       = 16;
	localparam int PROD_W     = 32;
	localparam int SUM_W      = 40;
	localparam int IDX_W      = 6;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 7;

	// stream word widths
	localparam int S_DATA_W = 2 * IN_W;
	localparam int M_DATA_W = ((SUM_W + IDX_W + 7) / 8) * 8;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_NUM_ROWS = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_NUM_COLS = CFG_IDX_W'(1);

	typedef enum logic [1:0] {
		ST_RUN,
		ST_WAIT,
		ST_DRAIN
	} state_t;

	// per-word accumulate command from control to datapath
	typedef struct packed {
		logic valid;
		logic first_row;
	} acc_cmd_t;

	// clamp a size register to 1..maxv
	function automatic logic [CFG_DATA_W-1:0] clamp_size(
		input logic [CFG_DATA_W-1:0] raw,
		input logic [CFG_DATA_W-1:0] maxv
	);
		logic [CFG_DATA_W-1:0] res;
		if (raw == '0) begin
			res = CFG_DATA_W'(1);
		end else if (raw > maxv) begin
			res = maxv;
		end else begin
			res = raw;
		end
		return res;
	endfunction

endpackage

/* rtl/vmm_acc.sv */
module vmm_acc #(
	parameter int MAX_COLS = vmm_pkg::MAX_COLS_DEF,
	parameter int COL_W    = 6
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  vmm_pkg::acc_cmd_t           acc_cmd,
	input  logic [COL_W-1:0]            col_addr,
	input  logic [COL_W-1:0]            rd_addr,
	input  logic [vmm_pkg::IN_W-1:0]    vector_element,
	input  logic [vmm_pkg::IN_W-1:0]    matrix_element,
	output logic [vmm_pkg::SUM_W-1:0]   rd_data
);
	import vmm_pkg::*;

	logic [SUM_W-1:0]  mem [MAX_COLS];
	logic [SUM_W-1:0]  rdata_q;
	logic [SUM_W-1:0]  wsum_q;
	logic [SUM_W-1:0]  base;
	logic [SUM_W-1:0]  sum;
	logic [PROD_W-1:0] prod_s1;
	logic [COL_W-1:0]  addr_s1;
	logic              first_s1;
	logic              valid_s1;
	logic              fwd_s1;

	// stage 1 control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			fwd_s1   <= 1'b0;
		end else begin
			valid_s1 <= acc_cmd.valid;
			// previous word writes the same entry at this edge
			fwd_s1   <= acc_cmd.valid && valid_s1 && (addr_s1 == col_addr);
		end
	end

	// multiply and stage 1 payload
	always_ff @(posedge clk) begin
		if (acc_cmd.valid) begin
			prod_s1  <= PROD_W'($signed(vector_element) * $signed(matrix_element));
			addr_s1  <= col_addr;
			first_s1 <= acc_cmd.first_row;
		end
	end

	// accumulate, first row starts from zero
	always_comb begin
		if (first_s1) begin
			base = '0;
		end else if (fwd_s1) begin
			base = wsum_q;
		end else begin
			base = rdata_q;
		end
		sum = base + {{(SUM_W-PROD_W){prod_s1[PROD_W-1]}}, prod_s1};
	end

	// column sum memory
	always_ff @(posedge clk) begin
		rdata_q <= mem[rd_addr];
		if (valid_s1) begin
			mem[addr_s1] <= sum;
			wsum_q       <= sum;
		end
	end

	assign rd_data = rdata_q;

	// forwarding only for a word that follows a word
	a_fwd_valid: assert property (@(posedge clk) disable iff (!arst_n)
		fwd_s1 |-> (valid_s1 && $past(valid_s1)))
		else $error("forward without a preceding write");

endmodule

/* rtl/vmm_ctrl.sv */
module vmm_ctrl #(
	parameter int MAX_ROWS = vmm_pkg::MAX_ROWS_DEF,
	parameter int MAX_COLS = vmm_pkg::MAX_COLS_DEF,
	parameter int ROW_W    = 6,
	parameter int COL_W    = 6
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_fire,
	input  logic [vmm_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [vmm_pkg::CFG_DATA_W-1:0]   cfg_data,
	input  logic                             in_fire,
	input  logic                             out_fire,
	output logic                             in_ready,
	output logic                             out_valid,
	output logic                             out_last,
	output logic [COL_W-1:0]                 out_index,
	output vmm_pkg::acc_cmd_t                acc_cmd,
	output logic [COL_W-1:0]                 col_addr,
	output logic [COL_W-1:0]                 rd_addr
);
	import vmm_pkg::*;

	state_t                state_q;
	state_t                state_d;
	logic [CFG_DATA_W-1:0] num_rows_q;
	logic [CFG_DATA_W-1:0] num_cols_q;
	logic [CFG_DATA_W-1:0] rows_m1;
	logic [CFG_DATA_W-1:0] cols_m1;
	logic [ROW_W-1:0]      row_q;
	logic [COL_W-1:0]      col_q;
	logic [COL_W-1:0]      idx_q;
	logic                  data_ok_q;
	logic                  row_last;
	logic                  col_last;
	logic                  idx_last;
	logic                  cfg_hit;

	// effective sizes
	assign rows_m1  = clamp_size(num_rows_q, CFG_DATA_W'(MAX_ROWS)) - CFG_DATA_W'(1);
	assign cols_m1  = clamp_size(num_cols_q, CFG_DATA_W'(MAX_COLS)) - CFG_DATA_W'(1);
	assign row_last = (row_q == rows_m1[ROW_W-1:0]);
	assign col_last = (col_q == cols_m1[COL_W-1:0]);
	assign idx_last = (idx_q == cols_m1[COL_W-1:0]);
	assign cfg_hit  = cfg_fire && (cfg_index == REG_NUM_ROWS || cfg_index == REG_NUM_COLS);

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_RUN: begin
				if (in_fire && col_last && row_last) state_d = ST_WAIT;
			end
			ST_WAIT: begin
				state_d = ST_DRAIN;
			end
			ST_DRAIN: begin
				if (out_fire && idx_last) state_d = ST_RUN;
			end
			default: state_d = ST_RUN;
		endcase
		if (cfg_hit) state_d = ST_RUN;
	end

	// outputs
	always_comb begin
		in_ready  = 1'b0;
		out_valid = 1'b0;
		rd_addr   = col_q;
		unique case (state_q)
			ST_RUN: begin
				in_ready = 1'b1;
			end
			ST_WAIT: begin
				rd_addr = idx_q;
			end
			ST_DRAIN: begin
				out_valid = data_ok_q;
				// read one ahead so the next word is ready after a handshake
				rd_addr   = (out_fire && !idx_last) ? idx_q + COL_W'(1) : idx_q;
			end
			default: begin
				in_ready = 1'b0;
			end
		endcase
	end

	assign out_index         = idx_q;
	assign out_last          = idx_last;
	assign col_addr          = col_q;
	assign acc_cmd.valid     = in_fire;
	assign acc_cmd.first_row = (row_q == '0);

	// registers, counters and state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_RUN;
			num_rows_q <= CFG_DATA_W'(1);
			num_cols_q <= CFG_DATA_W'(1);
			row_q      <= '0;
			col_q      <= '0;
			idx_q      <= '0;
			data_ok_q  <= 1'b0;
		end else begin
			state_q   <= state_d;
			data_ok_q <= (state_q == ST_DRAIN) && (state_d == ST_DRAIN);
			if (cfg_hit) begin
				if (cfg_index == REG_NUM_ROWS) num_rows_q <= cfg_data;
				if (cfg_index == REG_NUM_COLS) num_cols_q <= cfg_data;
				row_q <= '0;
				col_q <= '0;
				idx_q <= '0;
			end else begin
				if (in_fire) begin
					if (col_last) begin
						col_q <= '0;
						row_q <= row_last ? '0 : row_q + ROW_W'(1);
					end else begin
						col_q <= col_q + COL_W'(1);
					end
				end
				if (state_q == ST_WAIT) begin
					idx_q <= '0;
				end else if (out_fire) begin
					idx_q <= idx_last ? '0 : idx_q + COL_W'(1);
				end
			end
		end
	end

	// never take input while results are pending
	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(in_ready && out_valid))
		else $error("input accepted during drain");

	// the wait state for the final write-back moves on to drain in the next cycle
	a_wait_one: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_WAIT && !cfg_hit) |=> (state_q == ST_DRAIN))
		else $error("wait state held too long");

	// stalled result keeps its column
	a_idx_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_fire && !cfg_hit) |=> (out_valid && $stable(idx_q)))
		else $error("result column moved under stall");

	// counters stay within the configured sizes
	a_col_range: assert property (@(posedge clk) disable iff (!arst_n)
		(CFG_DATA_W'(col_q) <= cols_m1) && (CFG_DATA_W'(row_q) <= rows_m1))
		else $error("counter beyond configured size");

endmodule

/* rtl/vector_matrix_multiply.sv */
// Row vector times matrix, Q8.8 inputs and exact 40-bit Q24.16 column sums.
// Each input word carries one matrix element in row-major order together
// with the vector element of its row. One word is accepted per cycle while
// a run streams in; each product is added into a one-port-read column sum
// memory, with the previous write forwarded when one column repeats. The
// first row starts every column from zero, so no clearing pass is needed.
// After the last element of the last row the input stalls for the final
// write-back and the first memory read, then num_cols results leave in
// column order at one per cycle under no backpressure, last_result marking
// the final one. A write to num_rows or num_cols restarts the run; sizes
// of zero read as one and sizes above the maximum read as the maximum.
module vector_matrix_multiply #(
	parameter int MAX_ROWS = vmm_pkg::MAX_ROWS_DEF,
	parameter int MAX_COLS = vmm_pkg::MAX_COLS_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	// input stream
	input  logic                             s_tvalid,
	output logic                             s_tready,
	input  logic [vmm_pkg::S_DATA_W-1:0]     s_tdata,   // vector_element, matrix_element
	// result stream
	output logic                             m_tvalid,
	input  logic                             m_tready,
	output logic [vmm_pkg::M_DATA_W-1:0]     m_tdata,   // result_value, result_index, zero pad
	output logic                             m_tlast,
	// configuration
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [vmm_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [vmm_pkg::CFG_DATA_W-1:0]   cfg_data
);
	import vmm_pkg::*;

	localparam int ROW_W = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
	localparam int COL_W = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;

	acc_cmd_t          acc_cmd;
	logic [COL_W-1:0]  col_addr;
	logic [COL_W-1:0]  rd_addr;
	logic [COL_W-1:0]  out_index;
	logic [SUM_W-1:0]  rd_data;
	logic              in_fire;
	logic              out_fire;
	logic              cfg_fire;

	assign cfg_ready = 1'b1;
	assign cfg_fire  = cfg_valid && cfg_ready;
	assign in_fire   = s_tvalid && s_tready;
	assign out_fire  = m_tvalid && m_tready;

	// sequencing and counters
	vmm_ctrl #(
		.MAX_ROWS (MAX_ROWS),
		.MAX_COLS (MAX_COLS),
		.ROW_W    (ROW_W),
		.COL_W    (COL_W)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_fire  (cfg_fire),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_fire   (in_fire),
		.out_fire  (out_fire),
		.in_ready  (s_tready),
		.out_valid (m_tvalid),
		.out_last  (m_tlast),
		.out_index (out_index),
		.acc_cmd   (acc_cmd),
		.col_addr  (col_addr),
		.rd_addr   (rd_addr)
	);

	// multiply-accumulate over the column sum memory
	vmm_acc #(
		.MAX_COLS (MAX_COLS),
		.COL_W    (COL_W)
	) u_acc (
		.clk            (clk),
		.arst_n         (arst_n),
		.acc_cmd        (acc_cmd),
		.col_addr       (col_addr),
		.rd_addr        (rd_addr),
		.vector_element (s_tdata[IN_W-1:0]),
		.matrix_element (s_tdata[2*IN_W-1:IN_W]),
		.rd_data        (rd_data)
	);

	// result word packing
	assign m_tdata = M_DATA_W'({IDX_W'(out_index), rd_data});

endmodule

/* bench/vector_matrix_multiply_test.sv */
`timescale 1ns / 1ps

module vector_matrix_multiply_test;
	import vmm_pkg::*;

	// register indexes outside the list, which the block must ignore
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_2 = CFG_IDX_W'(2);
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_3 = CFG_IDX_W'(3);
	localparam int MAX_SIZE = 64;
	localparam int HOLD_CYCLES = 400;
	localparam int SETTLE_CYCLES = 8;

	typedef struct {
		logic signed [IN_W-1:0] vec;
		logic signed [IN_W-1:0] mat;
	} element_t;

	typedef struct {
		logic signed [SUM_W-1:0] value;
		logic [IDX_W-1:0]        column;
		logic                    last;
	} column_result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [S_DATA_W-1:0] s_tdata = '0;   // vector_element, matrix_element
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [M_DATA_W-1:0] m_tdata;        // result_value, result_index, zero pad
	logic m_tlast;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	vector_matrix_multiply uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// stimulus and expectations
	element_t elements_to_send[$];
	column_result_t column_sums_due[$];

	// shadow of the block state
	logic signed [SUM_W-1:0] col_sum [MAX_SIZE];
	int row_pos = 0;
	int col_pos = 0;
	logic [CFG_DATA_W-1:0] rows_raw = CFG_DATA_W'(1);
	logic [CFG_DATA_W-1:0] cols_raw = CFG_DATA_W'(1);

	// idling controls and bookkeeping
	int send_gap_pct = 0;
	int recv_stall_pct = 0;
	int hold_requests = 0;
	int holds_served = 0;
	int hold_left = 0;
	bit offering = 1'b0;
	element_t offered;
	int words_in = 0;
	int results_out = 0;
	int settings_seen = 0;
	int failures = 0;

	initial begin
		forever #4 clk = ~clk;
	end

	// size register as the block reads it
	function automatic int eff_size(input logic [CFG_DATA_W-1:0] raw);
		if (raw == '0) begin
			return 1;
		end
		return (raw > MAX_SIZE) ? MAX_SIZE : int'(raw);
	endfunction

	function automatic void clear_sums();
		foreach (col_sum[k]) col_sum[k] = '0;
		row_pos = 0;
		col_pos = 0;
	endfunction

	// one multiply-accumulate; a finished matrix yields all column sums
	function automatic void accumulate_element(input element_t e);
		logic signed [PROD_W-1:0] prod;
		int rows;
		int cols;
		column_result_t r;
		rows = eff_size(rows_raw);
		cols = eff_size(cols_raw);
		prod = e.vec * e.mat;
		col_sum[col_pos] = col_sum[col_pos] + prod;
		col_pos++;
		if (col_pos < cols) begin
			return;
		end
		col_pos = 0;
		row_pos++;
		if (row_pos < rows) begin
			return;
		end
		for (int k = 0; k < cols; k++) begin
			r.value = col_sum[k];
			r.column = IDX_W'(k);
			r.last = (k == cols - 1);
			column_sums_due.push_back(r);
		end
		clear_sums();
	endfunction

	// q8.8 value, biased toward the extremes
	function automatic logic signed [IN_W-1:0] rand_q88();
		case ($urandom_range(9))
			0: return 16'sh8000;
			1: return 16'sh7fff;
			2: return '0;
			3: return -16'sd1;
			default: return IN_W'($urandom);
		endcase
	endfunction

	function automatic void push_element(input int vec, input int mat);
		element_t e;
		e.vec = IN_W'(vec);
		e.mat = IN_W'(mat);
		elements_to_send.push_back(e);
	endfunction

	function automatic void push_random(input int count);
		element_t e;
		for (int i = 0; i < count; i++) begin
			e.vec = rand_q88();
			e.mat = rand_q88();
			elements_to_send.push_back(e);
		end
	endfunction

	// register write over the config channel
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		if (idx == REG_NUM_ROWS) begin
			rows_raw = val;
			clear_sums();
		end else if (idx == REG_NUM_COLS) begin
			cols_raw = val;
			clear_sums();
		end
	endtask

	// wait until all words went in and all sums came out, then let it settle
	task automatic wait_idle();
		do @(posedge clk);
		while (elements_to_send.size() != 0 || offering || column_sums_due.size() != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic set_idling(input int mode);
		case (mode % 4)
			0: begin send_gap_pct = 0;  recv_stall_pct = 0;  end
			1: begin send_gap_pct = 50; recv_stall_pct = 0;  end
			2: begin send_gap_pct = 0;  recv_stall_pct = 50; end
			default: begin send_gap_pct = 37; recv_stall_pct = 37; end
		endcase
	endtask

	// sizes, whole matrices, then maybe a short partial one dropped by the next write
	task automatic run_setting(input int rows_val, input int cols_val, input int runs,
			input int mode, input bit with_hold);
		int per_run;
		write_reg(REG_NUM_ROWS, CFG_DATA_W'(rows_val));
		write_reg(REG_NUM_COLS, CFG_DATA_W'(cols_val));
		settings_seen++;
		set_idling(mode);
		per_run = eff_size(rows_raw) * eff_size(cols_raw);
		if (with_hold) begin
			hold_requests++;
		end
		push_random(runs * per_run);
		if ($urandom_range(2) == 0) begin
			push_random($urandom_range((per_run > 16) ? 15 : per_run - 1));
		end
		wait_idle();
	endtask

	// sender: holds a word until it is taken
	always @(posedge clk) begin
		if (arst_n) begin
			if (s_tvalid && s_tready) begin
				accumulate_element(offered);
				words_in++;
				offering = 1'b0;
			end
			if (!offering && elements_to_send.size() != 0
					&& $urandom_range(99) >= send_gap_pct) begin
				offered = elements_to_send.pop_front();
				offering = 1'b1;
			end
			s_tvalid <= offering;
			s_tdata <= {offered.mat, offered.vec};
		end
	end

	// receiver: checks each column sum and decides on backpressure
	always @(posedge clk) begin
		column_result_t want;
		bit ready_next;
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				results_out++;
				if (column_sums_due.size() == 0) begin
					$error("column sum with nothing expected: value %0d index %0d",
						$signed(m_tdata[SUM_W-1:0]), m_tdata[SUM_W +: IDX_W]);
					failures++;
				end else begin
					want = column_sums_due.pop_front();
					if (m_tdata[SUM_W-1:0] !== want.value) begin
						$error("result_value expected %0d got %0d", want.value,
							$signed(m_tdata[SUM_W-1:0]));
						failures++;
					end
					if (m_tdata[SUM_W +: IDX_W] !== want.column) begin
						$error("result_index expected %0d got %0d", want.column,
							m_tdata[SUM_W +: IDX_W]);
						failures++;
					end
					if (m_tlast !== want.last) begin
						$error("last_result expected %0d got %0d", want.last, m_tlast);
						failures++;
					end
				end
			end
			if (hold_requests != holds_served) begin
				holds_served++;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				ready_next = 1'b0;
			end else begin
				ready_next = ($urandom_range(99) >= recv_stall_pct);
			end
			m_tready <= ready_next;
		end
	end

	initial begin
		int random_words;
		int mode;
		clear_sums();
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// sizes at reset: every word is a whole 1x1 product
		settings_seen++;
		push_element(-32768, -32768);
		push_element(32767, 32767);
		push_element(-32768, 32767);
		push_element(0, -1);
		push_element(-1, -1);
		push_element(1, -32768);
		wait_idle();

		// writes to spare indexes leave a partial run untouched
		write_reg(REG_NUM_ROWS, CFG_DATA_W'(2));
		write_reg(REG_NUM_COLS, CFG_DATA_W'(3));
		settings_seen++;
		push_random(3);
		wait_idle();
		write_reg(REG_SPARE_2, CFG_DATA_W'(5));
		write_reg(REG_SPARE_3, CFG_DATA_W'(127));
		push_random(3);
		wait_idle();

		// a size write drops a partial run; zero sizes read as one
		push_random(2);
		wait_idle();
		write_reg(REG_NUM_ROWS, '0);
		write_reg(REG_NUM_COLS, '0);
		settings_seen++;
		push_element(32767, -32768);
		push_element(-32768, -1);
		wait_idle();

		// largest sizes, then medium ones, with a long receiver hold-off
		run_setting(127, 1, 1, 0, 1'b0);
		run_setting(1, 64, 2, 1, 1'b1);
		run_setting(3, 4, 8, 2, 1'b0);
		run_setting(5, 2, 8, 3, 1'b0);
		run_setting(1, 65, 1, 0, 1'b0);
		random_words = 64 + 128 + 96 + 80 + 64;
		mode = 0;
		while (random_words < 470) begin
			int r;
			int c;
			int n;
			r = $urandom_range(8, 1);
			c = $urandom_range(8, 1);
			n = $urandom_range(5, 2);
			run_setting(r, c, n, mode, 1'b0);
			random_words += r * c * n;
			mode++;
		end

		wait_idle();
		repeat (20) @(posedge clk);
		$display("covered %0d input words and %0d column sums over %0d size settings,",
			words_in, results_out, settings_seen);
		$display("with stalls on both sides and a long hold-off of the result stream");
		if (failures == 0) begin
			$display("vector_matrix_multiply_test OK");
		end else begin
			$display("vector_matrix_multiply_test NOT OK");
		end
		$finish;
	end

	// run limit
	initial begin
		#2ms;
		$display("timeout");
		$display("vector_matrix_multiply_test NOT OK");
		$finish;
	end

endmodule
